FILE: rtl/multi_pattern_matcher_unit_assert.svh
// Assertion macros shared by the matcher RTL.
`ifndef MULTI_PATTERN_MATCHER_UNIT_ASSERT_SVH
`define MULTI_PATTERN_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mpm_pkg.sv
// Package with the command and status codes and the sequencer state type of the matcher.
package mpm_pkg;

    localparam int CMD_W   = 3;
    localparam int SYM_W   = 5;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PATTERN = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_BUILD = 2'd2;

    typedef enum logic [12:0] {
        ST_CLR   = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_INS   = 13'b0000000000100,
        ST_BRREQ = 13'b0000000001000,
        ST_BRDAT = 13'b0000000010000,
        ST_BPOP  = 13'b0000000100000,
        ST_BQDAT = 13'b0000001000000,
        ST_BFDAT = 13'b0000010000000,
        ST_BCRD  = 13'b0000100000000,
        ST_BVRD  = 13'b0001000000000,
        ST_BVDAT = 13'b0010000000000,
        ST_TDAT  = 13'b0100000000000,
        ST_TCHK  = 13'b1000000000000
    } state_t;

endpackage

FILE: rtl/mpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/multi_pattern_matcher_unit.sv
// Top level of the multi-pattern matcher: sequencer around the trie and node memories.
//
// Usage: one input channel (in_valid, in_stall, command, symbol, last) and one result
// channel (out_valid, out_stall, found_count, status). Every input transfer yields
// exactly one result transfer holding the distinct pattern count and a status code.
// The block takes one command at a time; in_stall is low only while the sequencer is
// idle and the result register is empty.
// Steps from input transfer to result valid, as set by the single read port of each memory:
//   restart, ignored commands, text before build, rest of a dropped pattern: registered on accept.
//   pattern symbol: one read of the transition memory, then the write back.
//   text symbol: one read of the transition memory, then one check per node visited on the
//   failure chain, plus one more when the walk stops at a node already marked seen rather than at the root.
//   build: a request and a data step per root letter, then per queued trie node a pop, a queue
//   read and a failure read, and per letter a child read, a failure-node read and a write step.
//   clear: a one-entry-per-cycle sweep of the transition memory.
// After reset the same clearing sweep runs with in_stall high;
// it gives no result. A stalled result is held unchanged in the output register, and
// no new item is taken until it has been transferred.
module multi_pattern_matcher_unit #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 26
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mpm_pkg::CMD_W-1:0]        command,
    input  logic [mpm_pkg::SYM_W-1:0]        symbol,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mpm_pkg::COUNT_W-1:0]      found_count,
    output logic [mpm_pkg::STAT_W-1:0]       status
);

`include "multi_pattern_matcher_unit_assert.svh"

    localparam int TOTAL = NODES * ALPHABET;
    localparam int AW    = $clog2(NODES);
    localparam int TW    = $clog2(TOTAL);
    localparam int CW    = $clog2(ALPHABET + 1);

    mpm_pkg::state_t state_reg, state_next;

    logic [TW-1:0]                   cnt_reg, cnt_next;
    logic                            clr_resp_reg, clr_resp_next;
    logic [AW:0]                     node_total_reg, node_total_next;
    logic [AW-1:0]                   ins_cur_reg, ins_cur_next;
    logic [AW-1:0]                   match_reg, match_next;
    logic [mpm_pkg::COUNT_W-1:0]     hit_reg, hit_next;
    logic                            built_reg, built_next;
    logic                            drop_reg, drop_next;
    logic                            out_valid_reg, out_valid_next;
    logic [mpm_pkg::STAT_W-1:0]      status_reg, status_next;
    logic [CW-1:0]                   c_reg, c_next;
    logic [AW:0]                     head_reg, head_next;
    logic [AW:0]                     tail_reg, tail_next;
    logic [AW-1:0]                   p_reg, p_next;
    logic [TW-1:0]                   pbase_reg, pbase_next;
    logic [TW-1:0]                   fbase_reg, fbase_next;
    logic [AW-1:0]                   child_reg, child_next;
    logic [AW-1:0]                   walk_reg, walk_next;
    logic [TW-1:0]                   slot_reg, slot_next;
    logic                            last_reg, last_next;

    // Memory ports.
    logic          t_we;
    logic [TW-1:0] t_waddr, t_raddr;
    logic [AW-1:0] t_wdata, t_rdata;
    logic          f_we;
    logic [AW-1:0] f_waddr, f_wdata, f_rdata;
    logic          pe_we, pe_wdata, pe_rdata;
    logic [AW-1:0] pe_waddr;
    logic          s_we, s_wdata, s_rdata;
    logic [AW-1:0] s_waddr;
    logic [AW-1:0] n_raddr;
    logic          q_we;
    logic [AW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

    logic          accept;
    logic          sym_ok;
    logic [AW-1:0] acc_node;
    logic [TW-1:0] acc_slot;

    assign accept   = in_valid && !in_stall;
    assign in_stall = !((state_reg == mpm_pkg::ST_IDLE) && !out_valid_reg);
    assign sym_ok   = int'(symbol) < ALPHABET;
    assign acc_node = (command == mpm_pkg::CMD_TEXT) ? match_reg : ins_cur_reg;
    assign acc_slot = TW'(acc_node) * TW'(ALPHABET) + TW'(symbol);

    mpm_ram #(.WIDTH(AW), .DEPTH(TOTAL)) u_next_ram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    mpm_ram #(.WIDTH(AW), .DEPTH(NODES)) u_fail_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(n_raddr), .rdata(f_rdata)
    );

    mpm_ram #(.WIDTH(1), .DEPTH(NODES)) u_end_ram (
        .clk(clk), .we(pe_we), .waddr(pe_waddr), .wdata(pe_wdata),
        .raddr(n_raddr), .rdata(pe_rdata)
    );

    mpm_ram #(.WIDTH(1), .DEPTH(NODES)) u_seen_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(n_raddr), .rdata(s_rdata)
    );

    mpm_ram #(.WIDTH(AW), .DEPTH(NODES)) u_queue_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    always_comb
    begin
        logic [AW-1:0] new_node;
        logic [AW:0]   tail_inc;
        logic [CW-1:0] c_inc;

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        clr_resp_next   = clr_resp_reg;
        node_total_next = node_total_reg;
        ins_cur_next    = ins_cur_reg;
        match_next      = match_reg;
        hit_next        = hit_reg;
        built_next      = built_reg;
        drop_next       = drop_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        c_next          = c_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        p_next          = p_reg;
        pbase_next      = pbase_reg;
        fbase_next      = fbase_reg;
        child_next      = child_reg;
        walk_next       = walk_reg;
        slot_next       = slot_reg;
        last_next       = last_reg;

        t_we     = 1'b0;
        t_waddr  = slot_reg;
        t_wdata  = '0;
        t_raddr  = acc_slot;
        f_we     = 1'b0;
        f_waddr  = '0;
        f_wdata  = '0;
        pe_we    = 1'b0;
        pe_waddr = '0;
        pe_wdata = 1'b1;
        s_we     = 1'b0;
        s_waddr  = walk_reg;
        s_wdata  = 1'b1;
        n_raddr  = walk_reg;
        q_we     = 1'b0;
        q_waddr  = tail_reg[AW-1:0];
        q_wdata  = '0;
        q_raddr  = head_reg[AW-1:0];

        new_node = node_total_reg[AW-1:0];
        tail_inc = tail_reg + (AW+1)'(1);
        c_inc    = c_reg + CW'(1);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            mpm_pkg::ST_CLR:
            begin
                t_we    = 1'b1;
                t_waddr = cnt_reg;
                t_wdata = '0;
                if (cnt_reg < TW'(NODES))
                begin
                    f_we     = 1'b1;
                    f_waddr  = cnt_reg[AW-1:0];
                    pe_we    = 1'b1;
                    pe_waddr = cnt_reg[AW-1:0];
                    pe_wdata = 1'b0;
                    s_we     = 1'b1;
                    s_waddr  = cnt_reg[AW-1:0];
                    s_wdata  = 1'b0;
                end
                if (cnt_reg == TW'(TOTAL - 1))
                begin
                    node_total_next = (AW+1)'(1);
                    ins_cur_next    = '0;
                    match_next      = '0;
                    hit_next        = '0;
                    built_next      = 1'b0;
                    drop_next       = 1'b0;
                    clr_resp_next   = 1'b0;
                    state_next      = mpm_pkg::ST_IDLE;
                    if (clr_resp_reg)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = mpm_pkg::STAT_OK;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + TW'(1);
                end
            end

            mpm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    status_next    = mpm_pkg::STAT_OK;
                    out_valid_next = 1'b1;
                    slot_next      = acc_slot;
                    last_next      = last;
                    case (command)
                        mpm_pkg::CMD_CLEAR:
                        begin
                            out_valid_next = 1'b0;
                            cnt_next       = '0;
                            clr_resp_next  = 1'b1;
                            state_next     = mpm_pkg::ST_CLR;
                        end
                        mpm_pkg::CMD_PATTERN:
                        begin
                            if (!built_reg && sym_ok)
                            begin
                                if (drop_reg)
                                begin
                                    status_next = mpm_pkg::STAT_FULL;
                                    if (last)
                                    begin
                                        ins_cur_next = '0;
                                        drop_next    = 1'b0;
                                    end
                                end
                                else
                                begin
                                    out_valid_next = 1'b0;
                                    state_next     = mpm_pkg::ST_INS;
                                end
                            end
                        end
                        mpm_pkg::CMD_BUILD:
                        begin
                            if (!built_reg)
                            begin
                                out_valid_next = 1'b0;
                                c_next         = '0;
                                head_next      = '0;
                                tail_next      = '0;
                                state_next     = mpm_pkg::ST_BRREQ;
                            end
                        end
                        mpm_pkg::CMD_RESTART:
                        begin
                            match_next = '0;
                        end
                        mpm_pkg::CMD_TEXT:
                        begin
                            if (!built_reg)
                            begin
                                status_next = mpm_pkg::STAT_NO_BUILD;
                            end
                            else if (sym_ok)
                            begin
                                out_valid_next = 1'b0;
                                state_next     = mpm_pkg::ST_TDAT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            mpm_pkg::ST_INS:
            begin
                out_valid_next = 1'b1;
                state_next     = mpm_pkg::ST_IDLE;
                if (t_rdata == '0)
                begin
                    if (node_total_reg >= (AW+1)'(NODES))
                    begin
                        status_next = mpm_pkg::STAT_FULL;
                        drop_next   = !last_reg;
                        if (last_reg)
                        begin
                            ins_cur_next = '0;
                        end
                    end
                    else
                    begin
                        t_we            = 1'b1;
                        t_waddr         = slot_reg;
                        t_wdata         = new_node;
                        node_total_next = node_total_reg + (AW+1)'(1);
                        ins_cur_next    = new_node;
                        if (last_reg)
                        begin
                            pe_we        = 1'b1;
                            pe_waddr     = new_node;
                            ins_cur_next = '0;
                        end
                    end
                end
                else
                begin
                    ins_cur_next = t_rdata;
                    if (last_reg)
                    begin
                        pe_we        = 1'b1;
                        pe_waddr     = t_rdata;
                        ins_cur_next = '0;
                    end
                end
            end

            mpm_pkg::ST_BRREQ:
            begin
                t_raddr    = TW'(c_reg);
                state_next = mpm_pkg::ST_BRDAT;
            end

            mpm_pkg::ST_BRDAT:
            begin
                if (t_rdata != '0 && tail_reg < (AW+1)'(NODES))
                begin
                    f_we      = 1'b1;
                    f_waddr   = t_rdata;
                    f_wdata   = '0;
                    q_we      = 1'b1;
                    q_wdata   = t_rdata;
                    tail_next = tail_inc;
                end
                c_next     = c_inc;
                state_next = mpm_pkg::ST_BRREQ;
                if (c_inc == CW'(ALPHABET))
                begin
                    state_next = (head_reg < tail_next) ? mpm_pkg::ST_BPOP : mpm_pkg::ST_IDLE;
                end
            end

            mpm_pkg::ST_BPOP:
            begin
                q_raddr    = head_reg[AW-1:0];
                head_next  = head_reg + (AW+1)'(1);
                state_next = mpm_pkg::ST_BQDAT;
            end

            mpm_pkg::ST_BQDAT:
            begin
                p_next     = q_rdata;
                n_raddr    = q_rdata;
                state_next = mpm_pkg::ST_BFDAT;
            end

            mpm_pkg::ST_BFDAT:
            begin
                pbase_next = TW'(p_reg) * TW'(ALPHABET);
                fbase_next = TW'(f_rdata) * TW'(ALPHABET);
                c_next     = '0;
                state_next = mpm_pkg::ST_BCRD;
            end

            mpm_pkg::ST_BCRD:
            begin
                t_raddr    = pbase_reg + TW'(c_reg);
                state_next = mpm_pkg::ST_BVRD;
            end

            mpm_pkg::ST_BVRD:
            begin
                child_next = t_rdata;
                t_raddr    = fbase_reg + TW'(c_reg);
                state_next = mpm_pkg::ST_BVDAT;
            end

            mpm_pkg::ST_BVDAT:
            begin
                if (child_reg != '0)
                begin
                    f_we    = 1'b1;
                    f_waddr = child_reg;
                    f_wdata = t_rdata;
                    if (tail_reg < (AW+1)'(NODES))
                    begin
                        q_we      = 1'b1;
                        q_wdata   = child_reg;
                        tail_next = tail_inc;
                    end
                end
                else
                begin
                    // Missing transition takes the one of the failure node.
                    t_we    = 1'b1;
                    t_waddr = pbase_reg + TW'(c_reg);
                    t_wdata = t_rdata;
                end
                c_next     = c_inc;
                state_next = mpm_pkg::ST_BCRD;
                if (c_inc == CW'(ALPHABET))
                begin
                    state_next = (head_reg < tail_next) ? mpm_pkg::ST_BPOP : mpm_pkg::ST_IDLE;
                end
            end

            mpm_pkg::ST_TDAT:
            begin
                match_next = t_rdata;
                walk_next  = t_rdata;
                n_raddr    = t_rdata;
                if (t_rdata == '0)
                begin
                    out_valid_next = 1'b1;
                    state_next     = mpm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mpm_pkg::ST_TCHK;
                end
            end

            mpm_pkg::ST_TCHK:
            begin
                if (s_rdata)
                begin
                    out_valid_next = 1'b1;
                    state_next     = mpm_pkg::ST_IDLE;
                end
                else
                begin
                    s_we      = 1'b1;
                    s_waddr   = walk_reg;
                    hit_next  = hit_reg + mpm_pkg::COUNT_W'(pe_rdata);
                    walk_next = f_rdata;
                    n_raddr   = f_rdata;
                    if (f_rdata == '0)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = mpm_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = mpm_pkg::ST_IDLE;
            end
        endcase

        // A finished build resets the cursors and marks the automaton ready.
        if ((state_reg == mpm_pkg::ST_BRDAT || state_reg == mpm_pkg::ST_BVDAT)
            && state_next == mpm_pkg::ST_IDLE)
        begin
            built_next     = 1'b1;
            ins_cur_next   = '0;
            match_next     = '0;
            drop_next      = 1'b0;
            out_valid_next = 1'b1;
            status_next    = mpm_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mpm_pkg::ST_CLR;
            cnt_reg        <= '0;
            clr_resp_reg   <= 1'b0;
            node_total_reg <= (AW+1)'(1);
            ins_cur_reg    <= '0;
            match_reg      <= '0;
            hit_reg        <= '0;
            built_reg      <= 1'b0;
            drop_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            c_reg          <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            clr_resp_reg   <= clr_resp_next;
            node_total_reg <= node_total_next;
            ins_cur_reg    <= ins_cur_next;
            match_reg      <= match_next;
            hit_reg        <= hit_next;
            built_reg      <= built_next;
            drop_reg       <= drop_next;
            out_valid_reg  <= out_valid_next;
            c_reg          <= c_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        p_reg      <= p_next;
        pbase_reg  <= pbase_next;
        fbase_reg  <= fbase_next;
        child_reg  <= child_next;
        walk_reg   <= walk_next;
        slot_reg   <= slot_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign found_count = hit_reg;
    assign status      = status_reg;

    `MPM_ASSERT_NOW(a_nodes_bound, 1'b1, node_total_reg <= (AW+1)'(NODES), "node count overflow")
    `MPM_ASSERT_NOW(a_built_cursor, built_reg, ins_cur_reg == '0, "insert cursor moved after build")
    `MPM_ASSERT_NOW(a_walk_built, state_reg == mpm_pkg::ST_TCHK, built_reg, "chain walk before build")
    `MPM_ASSERT_NEXT(a_accept_busy, accept, out_valid_reg || state_reg != mpm_pkg::ST_IDLE, "accepted item dropped")

endmodule

FILE: tb/multi_pattern_matcher_unit_tb.sv
// Self-checking testbench for the multi-pattern matcher top level.
`default_nettype none

module multi_pattern_matcher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES    = 1024;
    localparam int ALPHABET = 26;
    // Commands 5 to 7 have no meaning and must be ignored by the block.
    localparam logic [mpm_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [mpm_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam int SYM_MAX = (1 << mpm_pkg::SYM_W) - 1;
    // One clearing sweep per session and one full-trie build dominate the run,
    // so the ceiling is set well above their sum.
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [mpm_pkg::CMD_W-1:0]   command;
    logic [mpm_pkg::SYM_W-1:0]   symbol;
    logic                        last;
    logic                        out_valid;
    logic                        out_stall;
    logic [mpm_pkg::COUNT_W-1:0] found_count;
    logic [mpm_pkg::STAT_W-1:0]  status;

    multi_pattern_matcher_unit #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .symbol      (symbol),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found_count (found_count),
        .status      (status)
    );

    // One expected result transfer: the running count and the status code.
    typedef struct packed {
        logic [mpm_pkg::COUNT_W-1:0] count;
        logic [mpm_pkg::STAT_W-1:0]  code;
    } match_result_t;

    // One row of the directed stimulus. When typed is set, the expected result
    // is the one written in the row instead of the one the automaton model gives.
    typedef struct {
        logic [mpm_pkg::CMD_W-1:0]   cmd;
        logic [mpm_pkg::SYM_W-1:0]   sym;
        logic                        lst;
        bit                          typed;
        logic [mpm_pkg::COUNT_W-1:0] count;
        logic [mpm_pkg::STAT_W-1:0]  code;
    } stim_row_t;

    match_result_t pending_results[$];
    int unsigned   error_count;
    int unsigned   accepted_items;
    longint        cycle_count;
    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    bit            recv_hold;

    // Shadow automaton state, kept in the same shape as the block's memories.
    logic [9:0]  trie_next [NODES*ALPHABET];
    logic [9:0]  fail_to   [NODES];
    bit          is_end    [NODES];
    bit          visited   [NODES];
    logic [9:0]  walk_queue[NODES];
    int unsigned trie_nodes;
    int unsigned ins_node;
    int unsigned text_node;
    int unsigned distinct_hits;
    bit          links_built;
    bit          discarding;

    // Clear returns the automaton to its power-up contents.
    function automatic void trie_wipe();
        foreach (trie_next[i]) trie_next[i] = '0;
        foreach (fail_to[i])
        begin
            fail_to[i] = '0;
            is_end[i]  = 1'b0;
            visited[i] = 1'b0;
        end
        trie_nodes    = 1;
        ins_node      = 0;
        text_node     = 0;
        distinct_hits = 0;
        links_built   = 1'b0;
        discarding    = 1'b0;
    endfunction

    // Inserts one pattern letter. Once the trie is full, the rest of the
    // pattern is thrown away up to its final letter, which marks no end.
    function automatic logic [mpm_pkg::STAT_W-1:0] trie_insert(int unsigned c, bit fin);
        logic [mpm_pkg::STAT_W-1:0] code;
        int unsigned                child;
        code = mpm_pkg::STAT_OK;
        if (discarding)
            code = mpm_pkg::STAT_FULL;
        else
        begin
            child = trie_next[ins_node*ALPHABET + c];
            if (child == 0)
            begin
                if (trie_nodes >= NODES)
                begin
                    discarding = 1'b1;
                    code = mpm_pkg::STAT_FULL;
                end
                else
                begin
                    child = trie_nodes;
                    trie_next[ins_node*ALPHABET + c] = child[9:0];
                    trie_nodes++;
                end
            end
            if (!discarding)
                ins_node = child;
        end
        if (fin)
        begin
            if (!discarding)
                is_end[ins_node] = 1'b1;
            ins_node   = 0;
            discarding = 1'b0;
        end
        return code;
    endfunction

    // Breadth-first pass that sets failure links and fills absent transitions.
    function automatic void trie_link();
        int unsigned head;
        int unsigned tail;
        int unsigned p;
        int unsigned f;
        int unsigned child;
        int unsigned via;
        head = 0;
        tail = 0;
        for (int c = 0; c < ALPHABET; c++)
        begin
            child = trie_next[c];
            if (child != 0 && tail < NODES)
            begin
                fail_to[child] = '0;
                walk_queue[tail++] = child[9:0];
            end
        end
        while (head < tail)
        begin
            p = walk_queue[head++];
            f = fail_to[p];
            for (int c = 0; c < ALPHABET; c++)
            begin
                child = trie_next[p*ALPHABET + c];
                via   = trie_next[f*ALPHABET + c];
                if (child != 0)
                begin
                    fail_to[child] = via[9:0];
                    if (tail < NODES)
                        walk_queue[tail++] = child[9:0];
                end
                else
                    trie_next[p*ALPHABET + c] = via[9:0];
            end
        end
        links_built = 1'b1;
        ins_node    = 0;
        text_node   = 0;
        discarding  = 1'b0;
    endfunction

    // Follows one text letter, then walks the failure chain until the root or
    // a node already visited, counting every pattern end seen for the first time.
    function automatic void trie_scan(int unsigned c);
        int unsigned n;
        int unsigned steps;
        text_node = trie_next[text_node*ALPHABET + c];
        n = text_node;
        steps = 0;
        while (n != 0 && !visited[n] && steps < NODES)
        begin
            visited[n] = 1'b1;
            if (is_end[n])
                distinct_hits++;
            n = fail_to[n];
            steps++;
        end
    endfunction

    // Applies one accepted command to the shadow automaton and gives the result.
    function automatic match_result_t predict_match(logic [mpm_pkg::CMD_W-1:0] cmd,
                                                    logic [mpm_pkg::SYM_W-1:0] sym,
                                                    logic lst);
        match_result_t r;
        r.code = mpm_pkg::STAT_OK;
        case (cmd)
            mpm_pkg::CMD_CLEAR:
                trie_wipe();
            mpm_pkg::CMD_PATTERN:
                if (!links_built && sym < ALPHABET)
                    r.code = trie_insert(sym, lst);
            mpm_pkg::CMD_BUILD:
                if (!links_built)
                    trie_link();
            mpm_pkg::CMD_RESTART:
                text_node = 0;
            mpm_pkg::CMD_TEXT:
                if (!links_built)
                    r.code = mpm_pkg::STAT_NO_BUILD;
                else if (sym < ALPHABET)
                    trie_scan(sym);
            default:
                ;
        endcase
        r.count = distinct_hits[mpm_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // The idling mix moves through three phases as the run goes on.
    function automatic void update_idle_mix();
        if (accepted_items < 650)
        begin
            send_idle_pct  = 6;
            recv_stall_pct = 63;
        end
        else if (accepted_items < 1300)
        begin
            send_idle_pct  = 63;
            recv_stall_pct = 6;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endfunction

    // Offers one item and waits for its transfer. The expectation is queued at
    // the accepting edge, so results are always matched in order.
    task automatic send_item(logic [mpm_pkg::CMD_W-1:0] cmd, logic [mpm_pkg::SYM_W-1:0] sym,
                             logic lst, bit typed = 1'b0,
                             logic [mpm_pkg::COUNT_W-1:0] t_count = '0,
                             logic [mpm_pkg::STAT_W-1:0] t_code = mpm_pkg::STAT_OK);
        match_result_t r;
        if ($urandom_range(99) < send_idle_pct)
            repeat ($urandom_range(1, 4)) @(negedge clk);
        command  = cmd;
        symbol   = sym;
        last     = lst;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_match(cmd, sym, lst);
        if (typed)
        begin
            r.count = t_count;
            r.code  = t_code;
        end
        pending_results.push_back(r);
        accepted_items++;
        update_idle_mix();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // A harmless item that the block must answer without changing the trie.
    task automatic send_noise();
        case ($urandom_range(3))
            0: send_item(mpm_pkg::CMD_RESTART, $urandom_range(SYM_MAX), $urandom_range(1));
            1: send_item(mpm_pkg::CMD_TEXT, $urandom_range(SYM_MAX), $urandom_range(1));
            2: send_item($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI),
                         $urandom_range(SYM_MAX), $urandom_range(1));
            default: send_item(mpm_pkg::CMD_PATTERN, $urandom_range(ALPHABET, SYM_MAX),
                               $urandom_range(1));
        endcase
    endtask

    // One full session: clear, a handful of short patterns, the link build and
    // a stream of text with restarts. A small alphabet makes matches frequent.
    task automatic run_session(int unsigned alpha, int unsigned patterns, int unsigned letters);
        int unsigned len;
        send_item(mpm_pkg::CMD_CLEAR, $urandom_range(SYM_MAX), $urandom_range(1));
        for (int p = 0; p < patterns; p++)
        begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(99) < 4)
                    send_noise();
                // Now and then the final letter loses its end mark.
                send_item(mpm_pkg::CMD_PATTERN, $urandom_range(alpha - 1),
                          (k == len - 1) && ($urandom_range(99) >= 5));
            end
        end
        send_item(mpm_pkg::CMD_BUILD, $urandom_range(SYM_MAX), $urandom_range(1));
        for (int t = 0; t < letters; t++)
        begin
            if ($urandom_range(99) < 8)
                send_item(mpm_pkg::CMD_RESTART, $urandom_range(SYM_MAX), $urandom_range(1));
            else if ($urandom_range(99) < 4)
            begin
                case ($urandom_range(2))
                    0: send_item(mpm_pkg::CMD_BUILD, $urandom_range(SYM_MAX),
                                 $urandom_range(1));
                    1: send_item(mpm_pkg::CMD_PATTERN, $urandom_range(SYM_MAX),
                                 $urandom_range(1));
                    default: send_noise();
                endcase
            end
            else
                send_item(mpm_pkg::CMD_TEXT, $urandom_range(alpha - 1), $urandom_range(1));
        end
    endtask

    // Fills the trie to its last node with long random patterns, runs a few
    // more that overflow, then builds the full automaton once and scans random text.
    task automatic run_full_trie();
        send_item(mpm_pkg::CMD_CLEAR, '0, 1'b0);
        while (trie_nodes < NODES)
            for (int k = 0; k < 40; k++)
                send_item(mpm_pkg::CMD_PATTERN, $urandom_range(ALPHABET - 1), k == 39);
        for (int p = 0; p < 4; p++)
            for (int k = 0; k < 5; k++)
                send_item(mpm_pkg::CMD_PATTERN, $urandom_range(ALPHABET - 1), k == 4);
        send_item(mpm_pkg::CMD_BUILD, '0, 1'b0);
        for (int t = 0; t < 80; t++)
            send_item(mpm_pkg::CMD_TEXT, $urandom_range(ALPHABET - 1), 1'b0);
    endtask

    // Holds the result side off long enough that the block stalls its input.
    task automatic hold_receiver(int unsigned cycles);
        recv_hold = 1'b1;
        repeat (cycles) @(negedge clk);
        recv_hold = 1'b0;
    endtask

    // Directed rows: idle block, out-of-range and unused codes, four short
    // patterns, a repeated build, a pattern after the build, text, a restart
    // and a clear followed by text before any build.
    stim_row_t directed[] = '{
        '{mpm_pkg::CMD_TEXT,    5'd0,  1'b0, 1'b1, 11'd0, mpm_pkg::STAT_NO_BUILD},
        '{mpm_pkg::CMD_RESTART, 5'd31, 1'b1, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{CMD_UNUSED_HI,        5'd31, 1'b1, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{CMD_UNUSED_LO,        5'd0,  1'b0, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_PATTERN, 5'd31, 1'b1, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_PATTERN, 5'd0,  1'b0, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_PATTERN, 5'd1,  1'b1, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_PATTERN, 5'd25, 1'b1, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_PATTERN, 5'd1,  1'b1, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_PATTERN, 5'd0,  1'b1, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_BUILD,   5'd0,  1'b0, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_BUILD,   5'd31, 1'b1, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_PATTERN, 5'd2,  1'b1, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_TEXT,    5'd0,  1'b0, 1'b0, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_TEXT,    5'd1,  1'b0, 1'b0, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_TEXT,    5'd25, 1'b1, 1'b0, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_TEXT,    5'd30, 1'b0, 1'b0, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_RESTART, 5'd0,  1'b0, 1'b0, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_TEXT,    5'd0,  1'b0, 1'b0, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_TEXT,    5'd16, 1'b0, 1'b0, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_CLEAR,   5'd31, 1'b1, 1'b1, 11'd0, mpm_pkg::STAT_OK},
        '{mpm_pkg::CMD_TEXT,    5'd25, 1'b0, 1'b1, 11'd0, mpm_pkg::STAT_NO_BUILD}
    };

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Run ceiling, counted in clock cycles.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: stalls change at the falling edge, either at random or
    // while a long hold-off is in force.
    always @(negedge clk)
    begin
        if (recv_hold)
            out_stall = 1'b1;
        else
            out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    // Every result transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        match_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", found_count, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (found_count !== want.count)
                    report_mismatch("found_count", found_count, want.count);
                if (status !== want.code)
                    report_mismatch("status", status, want.code);
            end
        end
    end

    initial
    begin
        error_count    = 0;
        accepted_items = 0;
        cycle_count    = 0;
        recv_hold      = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = mpm_pkg::CMD_CLEAR;
        symbol         = '0;
        last           = 1'b0;
        out_stall      = 1'b0;
        update_idle_mix();
        trie_wipe();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // The block runs its clearing sweep first; the handshake simply waits.
        foreach (directed[i])
            send_item(directed[i].cmd, directed[i].sym, directed[i].lst,
                      directed[i].typed, directed[i].count, directed[i].code);

        run_session(3, 8, 60);

        // Long hold-off on the result side while items keep coming.
        fork
            hold_receiver(400);
        join_none
        run_session(26, 10, 60);

        // Let everything drain before the next session starts.
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);

        run_session(4, 6, 60);
        run_full_trie();
        run_session(2, 5, 60);
        run_session(26, 12, 60);
        run_session(5, 8, 60);

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
